/* sv/max_xor_subarray_trie_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the maximum subarray XOR block
// Shared property wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAX_XOR_SUBARRAY_TRIE_ASSERT_SVH
`define MAX_XOR_SUBARRAY_TRIE_ASSERT_SVH

// same-cycle implication
`define MXST_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mxst assertion failed");

// next-cycle implication
`define MXST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mxst assertion failed");

`endif

/* sv/mxst_pkg.sv */
// ----------------------------------------------------------------------------
// mxst_pkg
// Types and sizing constants for the maximum subarray XOR trie block.
// ----------------------------------------------------------------------------
package mxst_pkg;

    localparam int WIDTH     = 32;
    localparam int MAX_ITEMS = 512;

    // every item plus the zero prefix may add WIDTH nodes, plus the root
    localparam int NODE_CAP = WIDTH * (MAX_ITEMS + 1) + 1;
    localparam int NIDX_W   = $clog2(NODE_CAP);
    localparam int NCNT_W   = $clog2(NODE_CAP + 1);
    localparam int ENTRY_W  = 2 * NIDX_W;
    localparam int LVL_W    = $clog2(WIDTH);
    localparam int HELD_W   = $clog2(MAX_ITEMS + 1);

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } t_in;

    typedef struct packed {
        logic [31:0] max_xor;
        logic        overflow;
    } t_out;

    typedef struct packed {
        logic [WIDTH-1:0] value;
        logic             last;
        logic             drop;
    } t_qitem;

    typedef struct packed {
        logic              deq;
        logic              emit;
        logic [NCNT_W-1:0] node_count;
    } t_back_stat;

endpackage

/* sv/mxst_ram.sv */
// ----------------------------------------------------------------------------
// mxst_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mxst_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [DATA_W-1:0]          i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    output logic [DATA_W-1:0]          o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic [DATA_W-1:0]          o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* sv/mxst_front.sv */
// ----------------------------------------------------------------------------
// mxst_front
// Accepts input transactions and tags those beyond the set capacity as drops.
// ----------------------------------------------------------------------------
module mxst_front import mxst_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_in    i_in,
    input  logic   i_q_full,
    output logic   o_full,
    output logic   o_enq,
    output t_qitem o_qitem
);

    logic [HELD_W-1:0] r_held;
    logic [HELD_W-1:0] n_held;
    logic              accept;
    logic              drop;

    assign accept = i_push && !i_q_full;
    assign drop   = (r_held >= HELD_W'(MAX_ITEMS));

    always_comb begin
        n_held = r_held;
        if (accept) begin
            if (i_in.last) begin
                n_held = '0;
            end else if (!drop) begin
                n_held = r_held + HELD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else begin
            r_held <= n_held;
        end
    end

    assign o_full        = i_q_full;
    assign o_enq         = accept;
    assign o_qitem.value = i_in.value[WIDTH-1:0];
    assign o_qitem.last  = i_in.last;
    assign o_qitem.drop  = drop;

endmodule

/* sv/mxst_queue.sv */
// ----------------------------------------------------------------------------
// mxst_queue
// Short FIFO of classified items between the front and the trie engine.
// ----------------------------------------------------------------------------
module mxst_queue import mxst_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_enq,
    input  t_qitem i_data,
    input  logic   i_deq,
    output t_qitem o_data,
    output logic   o_full,
    output logic   o_empty
);

    t_qitem            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_level;
    logic              do_enq;
    logic              do_deq;

    assign o_full  = (r_level == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_level == '0);
    assign do_enq  = i_enq && !o_full;
    assign do_deq  = i_deq && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (do_enq) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_deq) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            unique case ({do_enq, do_deq})
                2'b10:   r_level <= r_level + (QPTR_W+1)'(1);
                2'b01:   r_level <= r_level - (QPTR_W+1)'(1);
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

/* sv/mxst_back.sv */
// ----------------------------------------------------------------------------
// mxst_back
// Trie engine: query and insert walks in lockstep, one level per cycle,
// running best, result register and rebuild of the zero chain per set.
// ----------------------------------------------------------------------------
module mxst_back import mxst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_qitem     i_qitem,
    input  logic       i_q_empty,
    input  logic       i_pop,
    output t_out       o_out,
    output logic       o_empty,
    output t_back_stat o_stat
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    logic [1:0]        r_state,     n_state;
    logic [LVL_W-1:0]  r_lvl,       n_lvl;
    logic [WIDTH-1:0]  r_prefix,    n_prefix;
    logic [WIDTH-1:0]  r_best,      n_best;
    logic [WIDTH-1:0]  r_acc,       n_acc;
    logic [NCNT_W-1:0] r_count,     n_count;
    logic [NIDX_W-1:0] r_inode,     n_inode;
    logic              r_qdone,     n_qdone;
    logic              r_idone,     n_idone;
    logic              r_fresh,     n_fresh;
    logic              r_last,      n_last;
    logic              r_ovf,       n_ovf;
    logic              r_out_valid, n_out_valid;
    t_out              r_out,       n_out;

    logic               we;
    logic [NIDX_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [NIDX_W-1:0]  raddr_q;
    logic [NIDX_W-1:0]  raddr_i;
    logic [ENTRY_W-1:0] rdata_q;
    logic [ENTRY_W-1:0] rdata_i;

    logic               deq;
    logic               emit;
    logic               want;
    logic               bsel;
    logic [NIDX_W-1:0]  q_want;
    logic [NIDX_W-1:0]  q_other;
    logic [ENTRY_W-1:0] cur;
    logic [NIDX_W-1:0]  cur_b;

    mxst_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (NODE_CAP)
    ) u_links (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_q),
        .o_rdata_a (rdata_q),
        .i_raddr_b (raddr_i),
        .o_rdata_b (rdata_i)
    );

    // link fields: upper half is the one-child, lower half the zero-child
    assign want    = ~r_prefix[r_lvl];
    assign bsel    = r_prefix[r_lvl];
    assign q_want  = want ? rdata_q[ENTRY_W-1:NIDX_W] : rdata_q[NIDX_W-1:0];
    assign q_other = want ? rdata_q[NIDX_W-1:0] : rdata_q[ENTRY_W-1:NIDX_W];
    assign cur     = r_fresh ? '0 : rdata_i;
    assign cur_b   = bsel ? cur[ENTRY_W-1:NIDX_W] : cur[NIDX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_prefix    = r_prefix;
        n_best      = r_best;
        n_acc       = r_acc;
        n_count     = r_count;
        n_inode     = r_inode;
        n_qdone     = r_qdone;
        n_idone     = r_idone;
        n_fresh     = r_fresh;
        n_last      = r_last;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = r_inode;
        wdata       = '0;
        raddr_q     = '0;
        raddr_i     = '0;
        deq         = 1'b0;
        emit        = 1'b0;

        if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                // hold a closing item until the result register is free
                if (!i_q_empty && (!i_qitem.last || !r_out_valid)) begin
                    deq = 1'b1;
                    if (i_qitem.drop) begin
                        n_ovf = 1'b1;
                        if (i_qitem.last) begin
                            emit = 1'b1;
                        end
                    end else begin
                        n_prefix = r_prefix ^ i_qitem.value;
                        n_last   = i_qitem.last;
                        n_lvl    = LVL_W'(WIDTH - 1);
                        n_acc    = '0;
                        n_qdone  = 1'b0;
                        n_idone  = 1'b0;
                        n_fresh  = 1'b0;
                        n_inode  = '0;
                        n_state  = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                // query: prefer the opposite bit, stop if the node has no child
                if (!r_qdone) begin
                    if (q_want != '0) begin
                        n_acc   = r_acc | ({{(WIDTH-1){1'b0}}, 1'b1} << r_lvl);
                        raddr_q = q_want;
                    end else if (q_other != '0) begin
                        raddr_q = q_other;
                    end else begin
                        n_qdone = 1'b1;
                    end
                end
                // insert: below the first new node every node is fresh
                if (!r_idone) begin
                    if (cur_b != '0) begin
                        n_inode = cur_b;
                    end else if (r_count >= NCNT_W'(NODE_CAP)) begin
                        n_idone = 1'b1;
                        n_ovf   = 1'b1;
                    end else begin
                        we      = 1'b1;
                        waddr   = r_inode;
                        wdata   = bsel ? {r_count[NIDX_W-1:0], cur[NIDX_W-1:0]}
                                       : {cur[ENTRY_W-1:NIDX_W], r_count[NIDX_W-1:0]};
                        n_count = r_count + NCNT_W'(1);
                        n_fresh = 1'b1;
                        n_inode = r_count[NIDX_W-1:0];
                    end
                end
                raddr_i = n_inode;
                if (r_lvl == '0) begin
                    if (n_acc > r_best) begin
                        n_best = n_acc;
                    end
                    if (r_last) begin
                        emit = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
            ST_CLEAR: begin
                // rebuild the zero chain: node k links its zero-child to k+1
                we    = 1'b1;
                waddr = NIDX_W'(r_lvl);
                wdata = {{NIDX_W{1'b0}}, NIDX_W'(r_lvl) + NIDX_W'(1)};
                if (r_lvl == LVL_W'(WIDTH - 1)) begin
                    n_count = NCNT_W'(WIDTH + 1);
                    n_state = ST_IDLE;
                end else begin
                    n_lvl = r_lvl + LVL_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid      = 1'b1;
            n_out.max_xor    = n_best;
            n_out.overflow   = n_ovf;
            n_prefix         = '0;
            n_best           = '0;
            n_ovf            = 1'b0;
            n_lvl            = '0;
            n_state          = ST_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_lvl       <= '0;
            r_prefix    <= '0;
            r_best      <= '0;
            r_count     <= NCNT_W'(WIDTH + 1);
            r_qdone     <= 1'b0;
            r_idone     <= 1'b0;
            r_fresh     <= 1'b0;
            r_last      <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_prefix    <= n_prefix;
            r_best      <= n_best;
            r_count     <= n_count;
            r_qdone     <= n_qdone;
            r_idone     <= n_idone;
            r_fresh     <= n_fresh;
            r_last      <= n_last;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_inode <= n_inode;
        r_out   <= n_out;
    end

    assign o_out             = r_out;
    assign o_empty           = !r_out_valid;
    assign o_stat.deq        = deq;
    assign o_stat.emit       = emit;
    assign o_stat.node_count = r_count;

endmodule

/* sv/max_xor_subarray_trie.sv */
// ----------------------------------------------------------------------------
// max_xor_subarray_trie
// Maximum XOR over any contiguous run of a set of values, via a binary trie.
// ----------------------------------------------------------------------------
// Each input transaction carries one value and a last flag. Accepted items
// wait in a four-entry queue; the trie engine takes one item at a time and
// walks the 32 trie levels with one read per level on each of the two RAM
// ports (query and insert in lockstep): it first takes the item from the
// queue, then steps through the levels. Items beyond 512 in a set are
// flagged and dropped without a walk. On the item marked last the result
// goes into the output register and the engine rebuilds the zero-prefix
// chain in the node store before it takes the next item; the same rebuild
// runs after reset. A closing item stays in the queue while the previous
// result has not yet been popped, so a slow result side stalls the engine
// and, once the queue fills, the input. Input transactions are taken into
// the queue throughout while it has room.
`include "max_xor_subarray_trie_assert.svh"

module max_xor_subarray_trie import mxst_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_in,
    output logic o_full,
    input  logic i_pop,
    output t_out o_out,
    output logic o_empty
);

    t_qitem     f_qitem;
    t_qitem     q_item;
    logic       f_enq;
    logic       q_full;
    logic       q_empty;
    t_back_stat stat;

    mxst_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_full   (o_full),
        .o_enq    (f_enq),
        .o_qitem  (f_qitem)
    );

    mxst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enq   (f_enq),
        .i_data  (f_qitem),
        .i_deq   (stat.deq),
        .o_data  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mxst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_qitem   (q_item),
        .i_q_empty (q_empty),
        .i_pop     (i_pop),
        .o_out     (o_out),
        .o_empty   (o_empty),
        .o_stat    (stat)
    );

    `MXST_ASSERT_IMPL(a_deq_has_item, stat.deq, !q_empty)
    `MXST_ASSERT_IMPL(a_node_cap, stat.deq || !stat.deq, stat.node_count <= NCNT_W'(NODE_CAP))
    `MXST_ASSERT_NEXT(a_emit_fills_out, stat.emit, !o_empty)
    `MXST_ASSERT_IMPL(a_emit_slot_free, stat.emit, o_empty || i_pop)

endmodule
